### hdl/ofps_pkg.sv
package ofps_pkg;

  localparam int MAX_COLS = 4096;
  localparam int MAX_ROWS = 4096;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int OUT_W  = 12;
  localparam int SIZE_W = 13;
  localparam int DIR_W  = 2;
  localparam int PIX_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int IDX_W_A = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int IDX_W   = (IDX_W_A > OUT_W) ? IDX_W_A : OUT_W;
  localparam int LIM_W   = (IDX_W + 1 > SIZE_W) ? IDX_W + 1 : SIZE_W;
  localparam int ENTRY_W = OUT_W + 1;

  localparam logic [PIX_W-1:0]  FG_VALUE     = 8'd255;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd2304;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd1536;

  typedef enum logic [DIR_W-1:0] {
    DIR_TOP    = 2'd0,
    DIR_RIGHT  = 2'd1,
    DIR_BOTTOM = 2'd2,
    DIR_LEFT   = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic             last_col;
    logic             last_row;
  } pos_t;

endpackage

### hdl/ofps_raster_cnt.sv
module ofps_raster_cnt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic [ofps_pkg::SIZE_W-1:0] image_width,
  input  logic [ofps_pkg::SIZE_W-1:0] image_height,
  output ofps_pkg::pos_t             pos
);
  import ofps_pkg::*;

  logic [IDX_W-1:0] col_r, col_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [LIM_W-1:0] w_lim, h_lim, w_ext, h_ext;
  logic [LIM_W-1:0] col_inc, row_inc;

  assign w_ext = LIM_W'(image_width);
  assign h_ext = LIM_W'(image_height);

  always_comb begin
    if (w_ext == '0) begin
      w_lim = LIM_W'(1);
    end else if (w_ext > LIM_W'(MAX_COLS)) begin
      w_lim = LIM_W'(MAX_COLS);
    end else begin
      w_lim = w_ext;
    end
    if (h_ext == '0) begin
      h_lim = LIM_W'(1);
    end else if (h_ext > LIM_W'(MAX_ROWS)) begin
      h_lim = LIM_W'(MAX_ROWS);
    end else begin
      h_lim = h_ext;
    end
  end

  assign col_inc = LIM_W'(col_r) + LIM_W'(1);
  assign row_inc = LIM_W'(row_r) + LIM_W'(1);

  assign pos.col      = col_r;
  assign pos.row      = row_r;
  assign pos.last_col = (col_inc >= w_lim);
  assign pos.last_row = (row_inc >= h_lim);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (pos.last_col) begin
        col_nxt = '0;
        row_nxt = pos.last_row ? '0 : row_inc[IDX_W-1:0];
      end else begin
        col_nxt = col_inc[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### hdl/ofps_col_store.sv
module ofps_col_store (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [ofps_pkg::COL_W-1:0]   rd_addr,
  input  logic                         wr_en,
  input  logic [ofps_pkg::COL_W-1:0]   wr_addr,
  input  logic [ofps_pkg::ENTRY_W-1:0] wr_data,
  output logic [ofps_pkg::ENTRY_W-1:0] rd_data
);
  import ofps_pkg::*;

  logic [ENTRY_W-1:0] mem [MAX_COLS];
  logic [ENTRY_W-1:0] mem_q_r;
  logic [ENTRY_W-1:0] fwd_data_r;
  logic               fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // same-address write in the read cycle: take the new entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : mem_q_r;

endmodule

### hdl/outermost_foreground_pixel_scan.sv
// Channel | Signals                                  | Direction
// in      | in_valid, in_ready, in_pixel              | pixel stream in, raster order
// out     | out_valid, out_ready, out_scan_index,     | edge transactions out
//         | out_edge_position                         |
// cfg     | cfg_wr_en, cfg_index, cfg_data            | register writes
//
// One pixel per cycle sustained while the output is not stalled; a result passes the stage-1 and output registers.
// Column store is read when a pixel is taken and, in column modes, written back one stage later,
// with a bypass for back-to-back use of the same column.
// Synchronous active-low reset clears counters, row flag and valids; store is not cleared.
// A stalled output holds; input keeps flowing until the stage ahead is full.
module outermost_foreground_pixel_scan (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ofps_pkg::PIX_W-1:0]      in_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ofps_pkg::OUT_W-1:0]      out_scan_index,
  output logic [ofps_pkg::OUT_W-1:0]      out_edge_position,
  input  logic                            cfg_wr_en,
  input  logic [ofps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ofps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ofps_pkg::*;

  dir_t              dir_r;
  logic [SIZE_W-1:0] width_r, height_r;

  logic              in_acc;
  pos_t              pos;

  logic              s1_v_r;
  logic              s1_fg_r;
  dir_t              s1_dir_r;
  pos_t              s1_pos_r;
  logic              s1_adv;
  logic              s1_col_mode;

  logic [ENTRY_W-1:0] st_rd;
  logic [ENTRY_W-1:0] e_in, e_new;
  logic               st_wr;

  logic              hit_r, hit_nxt;
  logic [OUT_W-1:0]  edge_col_r, edge_col_nxt;
  logic              flag0;

  logic              res_v;
  logic [OUT_W-1:0]  res_idx, res_pos;

  logic              out_v_r, out_v_nxt;
  logic [OUT_W-1:0]  out_idx_r, out_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= DIR_TOP;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DIRECTION: dir_r    <= dir_t'(cfg_data[DIR_W-1:0]);
        REG_WIDTH:     width_r  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT:    height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  ofps_raster_cnt u_cnt (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_acc),
    .image_width  (width_r),
    .image_height (height_r),
    .pos          (pos)
  );

  ofps_col_store u_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (pos.col[COL_W-1:0]),
    .wr_en   (st_wr),
    .wr_addr (s1_pos_r.col[COL_W-1:0]),
    .wr_data (e_new),
    .rd_data (st_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_fg_r  <= (in_pixel == FG_VALUE);
      s1_dir_r <= dir_r;
      s1_pos_r <= pos;
    end
  end

  assign s1_col_mode = (s1_dir_r == DIR_TOP) || (s1_dir_r == DIR_BOTTOM);

  // column modes: update stored first/last hit row
  always_comb begin
    e_in  = (s1_pos_r.row == '0) ? '0 : st_rd;
    e_new = e_in;
    if (s1_fg_r && ((s1_dir_r == DIR_BOTTOM) || !e_in[OUT_W])) begin
      e_new = {1'b1, s1_pos_r.row[OUT_W-1:0]};
    end
  end

  assign st_wr = s1_adv && s1_col_mode;

  // row modes: track first/last hit column
  always_comb begin
    flag0        = (s1_pos_r.col == '0) ? 1'b0 : hit_r;
    hit_nxt      = flag0;
    edge_col_nxt = edge_col_r;
    if (s1_fg_r && ((s1_dir_r == DIR_RIGHT) || !flag0)) begin
      hit_nxt      = 1'b1;
      edge_col_nxt = s1_pos_r.col[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r      <= 1'b0;
      edge_col_r <= '0;
    end else if (s1_adv && !s1_col_mode) begin
      hit_r      <= hit_nxt;
      edge_col_r <= edge_col_nxt;
    end
  end

  always_comb begin
    if (s1_col_mode) begin
      res_v   = s1_pos_r.last_row && e_new[OUT_W];
      res_idx = s1_pos_r.col[OUT_W-1:0];
      res_pos = e_new[OUT_W-1:0];
    end else begin
      res_v   = s1_pos_r.last_col && hit_nxt;
      res_idx = s1_pos_r.row[OUT_W-1:0];
      res_pos = edge_col_nxt;
    end
  end

  assign out_v_nxt = s1_adv ? res_v : (out_v_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_idx_r <= res_idx;
      out_pos_r <= res_pos;
    end
  end

  assign out_valid         = out_v_r;
  assign out_scan_index    = out_idx_r;
  assign out_edge_position = out_pos_r;

endmodule
